@@ hdl/rtrd_pkg.sv @@
package rtrd_pkg;

    // frame layout
    localparam int          MAX_FRAME_BYTES_DEF = 80;
    localparam int          HEAD_BYTES          = 11;
    localparam logic [31:0] HEADER_WORD         = 32'hF4F3F2F1;
    localparam logic [7:0]  FOOTER_FIRST        = 8'hF8;
    localparam logic [7:0]  MARKER_HEAD         = 8'hAA;
    localparam logic [7:0]  MARKER_TAIL         = 8'h55;
    localparam int          LEN_W               = 16;

    // fixed positions inside a frame (header bytes included)
    localparam int POS_LEN_LO   = 4;
    localparam int POS_LEN_HI   = 5;
    localparam int POS_PAYLOAD  = 6;
    localparam int POS_DROP     = 8;
    localparam int FRAME_EXTRA  = 10;

    // payload byte positions
    localparam int PB_MARK_A  = 1;
    localparam int PB_STATE   = 2;
    localparam int PB_MDIST_L = 3;
    localparam int PB_MDIST_H = 4;
    localparam int PB_MENER   = 5;
    localparam int PB_SDIST_L = 6;
    localparam int PB_SDIST_H = 7;
    localparam int PB_SENER   = 8;
    localparam int PB_MARK_B  = 9;

    // target states
    localparam logic [7:0] TS_MOVING = 8'd1;
    localparam logic [7:0] TS_STATIC = 8'd2;
    localparam logic [7:0] TS_BOTH   = 8'd3;

    typedef enum logic {
        PH_HUNT,
        PH_FRAME
    } t_phase;

    typedef enum logic [1:0] {
        ST_DECODED     = 2'd0,
        ST_TOO_SHORT   = 2'd1,
        ST_BAD_MARKERS = 2'd2
    } t_status;

    typedef logic [HEAD_BYTES-1:0][7:0] t_head;

    typedef struct packed {
        logic             emit;
        logic [LEN_W-1:0] length;
    } t_frame_info;

    typedef struct packed {
        t_status     status;
        logic [6:0]  payload_length;
        logic [7:0]  target_state;
        logic [15:0] moving_distance;
        logic [7:0]  moving_energy;
        logic [15:0] static_distance;
        logic [7:0]  static_energy;
        logic        has_target;
        logic [15:0] target_distance;
    } t_report;

endpackage

@@ hdl/rtrd_in_if.sv @@
interface rtrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/rtrd_out_if.sv @@
interface rtrd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  payload_length;
    logic [7:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_energy;
    logic [15:0] static_distance;
    logic [7:0]  static_energy;
    logic        has_target;
    logic [15:0] target_distance;

    modport source (
        output valid, output status, output payload_length, output target_state,
        output moving_distance, output moving_energy, output static_distance,
        output static_energy, output has_target, output target_distance,
        input ready
    );
    modport sink (
        input valid, input status, input payload_length, input target_state,
        input moving_distance, input moving_energy, input static_distance,
        input static_energy, input has_target, input target_distance,
        output ready
    );
endinterface

@@ hdl/rtrd_parser.sv @@
module rtrd_parser import rtrd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_stb,
    input  logic [7:0]  i_byte,
    output t_frame_info o_info,
    output t_head       o_head
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int TOT_W = LEN_W + 1;

    t_phase             r_phase, n_phase;
    logic [31:0]        r_window, n_window;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_fgood, n_fgood;
    t_head              r_head;

    logic [LEN_W-1:0]   w_len_cur;
    logic [TOT_W-1:0]   w_total;
    logic [TOT_W-1:0]   w_foot_start;
    logic [TOT_W-1:0]   w_pos_ext;
    logic [TOT_W-1:0]   w_foot_off;
    logic [7:0]         w_expect;
    logic [31:0]        w_shift;
    logic               w_hdr_hit;
    logic               w_in_payload;
    logic               w_head_wr;
    logic [3:0]         w_head_idx;
    logic               w_drop;
    logic               w_done;

    // length as seen with the current byte folded in
    always_comb begin
        w_len_cur = r_len;
        if (r_pos == POS_W'(POS_LEN_LO)) begin
            w_len_cur = {8'h00, i_byte};
        end else if (r_pos == POS_W'(POS_LEN_HI)) begin
            w_len_cur = {i_byte, r_len[7:0]};
        end
    end

    // frame geometry for the current byte
    assign w_total      = TOT_W'(w_len_cur) + TOT_W'(FRAME_EXTRA);
    assign w_foot_start = TOT_W'(w_len_cur) + TOT_W'(POS_PAYLOAD);
    assign w_pos_ext    = TOT_W'(r_pos);
    assign w_foot_off   = w_pos_ext - w_foot_start;
    assign w_expect     = FOOTER_FIRST - {6'd0, w_foot_off[1:0]};
    assign w_shift      = {r_window[23:0], i_byte};
    assign w_hdr_hit    = (w_shift == HEADER_WORD);
    assign w_in_payload = (r_pos >= POS_W'(POS_PAYLOAD)) && (w_pos_ext < w_foot_start);
    assign w_head_wr    = w_in_payload && (r_pos < POS_W'(POS_PAYLOAD + HEAD_BYTES));
    assign w_head_idx   = 4'(r_pos - POS_W'(POS_PAYLOAD));
    assign n_pos        = (r_phase == PH_HUNT) ? POS_W'(POS_LEN_LO) : r_pos + POS_W'(1);
    assign w_drop       = (r_phase == PH_FRAME) && (n_pos == POS_W'(POS_DROP))
                          && (w_total > TOT_W'(MAX_FRAME_BYTES));
    assign w_done       = (r_phase == PH_FRAME) && (n_pos >= POS_W'(POS_DROP))
                          && (TOT_W'(n_pos) == w_total);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (w_hdr_hit) begin
                    n_phase = PH_FRAME;
                end
            end
            PH_FRAME: begin
                if (w_drop || w_done) begin
                    n_phase = PH_HUNT;
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // window, length and footer check
    always_comb begin
        n_window = r_window;
        n_len    = r_len;
        n_fgood  = r_fgood;
        unique case (r_phase)
            PH_HUNT: begin
                n_window = w_shift;
                if (w_hdr_hit) begin
                    n_len   = '0;
                    n_fgood = 1'b1;
                end
            end
            PH_FRAME: begin
                n_len = w_len_cur;
                if (r_pos >= POS_W'(POS_PAYLOAD) && !w_in_payload && i_byte != w_expect) begin
                    n_fgood = 1'b0;
                end
                if (w_drop || w_done) begin
                    n_window = '0;
                end
            end
            default: n_window = '0;
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_window <= '0;
            r_len    <= '0;
            r_pos    <= '0;
            r_fgood  <= 1'b1;
        end else if (i_stb) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_fgood  <= n_fgood;
        end
    end

    // payload capture, first bytes only
    always_ff @(posedge i_clk) begin
        if (i_stb && r_phase == PH_FRAME && w_head_wr) begin
            r_head[w_head_idx] <= i_byte;
        end
    end

    // the last footer byte never writes the capture, so it is read as stored
    assign o_info.emit   = i_stb && w_done && n_fgood;
    assign o_info.length = r_len;
    assign o_head        = r_head;

    a_emit_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_info.emit |=> (r_phase == PH_HUNT) && (r_window == '0))
        else $error("parser did not restart hunting after a frame");

    a_emit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_info.emit |-> (r_phase == PH_FRAME) && (r_pos >= POS_W'(POS_DROP - 1)))
        else $error("item emitted outside a frame");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FRAME) |-> (r_pos >= POS_W'(POS_LEN_LO))
            && (TOT_W'(r_pos) < TOT_W'(MAX_FRAME_BYTES)))
        else $error("frame position out of range");

endmodule

@@ hdl/rtrd_decode.sv @@
module rtrd_decode import rtrd_pkg::*; (
    input  logic [LEN_W-1:0] i_length,
    input  t_head            i_head,
    output t_report          o_report
);

    logic [15:0] w_md;
    logic [15:0] w_sd;
    logic [7:0]  w_state;

    assign w_md    = {i_head[PB_MDIST_H], i_head[PB_MDIST_L]};
    assign w_sd    = {i_head[PB_SDIST_H], i_head[PB_SDIST_L]};
    assign w_state = i_head[PB_STATE];

    // status first, fields only for a good report
    always_comb begin
        o_report                = '0;
        o_report.payload_length = i_length[6:0];
        if (i_length < LEN_W'(HEAD_BYTES)) begin
            o_report.status = ST_TOO_SHORT;
        end else if (i_head[PB_MARK_A] != MARKER_HEAD || i_head[PB_MARK_B] != MARKER_TAIL) begin
            o_report.status = ST_BAD_MARKERS;
        end else begin
            o_report.status          = ST_DECODED;
            o_report.target_state    = w_state;
            o_report.moving_distance = w_md;
            o_report.moving_energy   = i_head[PB_MENER];
            o_report.static_distance = w_sd;
            o_report.static_energy   = i_head[PB_SENER];
            o_report.has_target      = (w_state == TS_MOVING) || (w_state == TS_STATIC)
                                       || (w_state == TS_BOTH);
            case (w_state)
                TS_MOVING: o_report.target_distance = w_md;
                TS_STATIC: o_report.target_distance = w_sd;
                TS_BOTH: begin
                    if (w_md == 16'd0) begin
                        o_report.target_distance = w_sd;
                    end else if (w_sd == 16'd0) begin
                        o_report.target_distance = w_md;
                    end else begin
                        o_report.target_distance = (w_md < w_sd) ? w_md : w_sd;
                    end
                end
                default: o_report.target_distance = 16'd0;
            endcase
        end
    end

endmodule

@@ hdl/radar_target_report_decoder.sv @@
// a report becomes valid at the edge on which the parser takes the last footer byte
// throughput: one byte per cycle while the report slot is not stalled, set by the single parser pass per byte
// a byte register feeds the parser and a report register holds the result
// a stalled report holds the byte register only once that register is full
// reset (synchronous, active low) empties both registers and restarts header hunting
module radar_target_report_decoder import rtrd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rtrd_in_if.sink         i_in,
    rtrd_out_if.source      o_out
);

    logic        r_s1_valid, n_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_out_valid, n_out_valid;
    t_report     r_rep;

    logic        w_adv;
    logic        w_in_acc;
    t_frame_info w_info;
    t_head       w_head;
    t_report     w_rep;

    // byte moves on when the report slot is free or being emptied
    assign w_adv       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_adv;
    assign w_in_acc    = i_in.valid && i_in.ready;

    rtrd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stb   (w_adv),
        .i_byte  (r_s1_byte),
        .o_info  (w_info),
        .o_head  (w_head)
    );

    rtrd_decode u_decode (
        .i_length (w_info.length),
        .i_head   (w_head),
        .o_report (w_rep)
    );

    // occupancy of both registers
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_in_acc) begin
            n_s1_valid = 1'b1;
        end else if (w_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_info.emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_byte <= i_in.rx_byte;
        end
        if (w_info.emit) begin
            r_rep <= w_rep;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_rep.status;
    assign o_out.payload_length  = r_rep.payload_length;
    assign o_out.target_state    = r_rep.target_state;
    assign o_out.moving_distance = r_rep.moving_distance;
    assign o_out.moving_energy   = r_rep.moving_energy;
    assign o_out.static_distance = r_rep.static_distance;
    assign o_out.static_energy   = r_rep.static_energy;
    assign o_out.has_target      = r_rep.has_target;
    assign o_out.target_distance = r_rep.target_distance;

    a_no_emit_into_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_info.emit |-> (!r_out_valid || o_out.ready))
        else $error("report overwritten before it was taken");

    a_byte_kept_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid && $stable(r_s1_byte))
        else $error("held byte lost while the report slot was full");

    a_bad_report_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rep.status != ST_DECODED) |->
            (r_rep.target_distance == 16'd0) && !r_rep.has_target
            && (r_rep.target_state == 8'd0))
        else $error("undecoded report carries target fields");

endmodule
